/* src/tvd_pkg.sv */
// Shared constants, types and tables of the tilt-to-velocity dead band core.
package tvd_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 14;
   localparam int ACC_W        = 16;
   localparam int SCALE_SHIFT  = 16;
   localparam int TAB_LEN      = 24;
   localparam int TAB_FRAC     = 30;

   // CORDIC datapath widths: x/y carry the scaled sample plus gain headroom,
   // z holds angles up to pi plus the sum of the rotation table
   localparam int X_W         = ACC_W + SCALE_SHIFT + 4;
   localparam int Z_W         = TAB_FRAC + 5;
   localparam int ROUND_SHIFT = TAB_FRAC - FRAC_BITS;
   localparam int ANG_W       = Z_W - ROUND_SHIFT;

   // Register and result widths
   localparam int DZ_W      = 14;
   localparam int LIM_W     = 14;
   localparam int GAIN_W    = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_W     = 16;
   localparam int PROD_W    = ANG_W + GAIN_W + 1;
   localparam int SH_W      = PROD_W - FRAC_BITS;

   // Prep stage, CORDIC steps, rounding, band, multiply and output stages
   localparam int PIPE_LATENCY = CORDIC_STEPS + 5;

   localparam logic signed [Z_W-1:0] PI_Q30     = Z_W'(64'sd3373259426);
   localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1) <<< (ROUND_SHIFT - 1);

   // atan(2^-i) in Q30
   localparam logic signed [Z_W-1:0] ATAN_Q30 [TAB_LEN] = '{
      Z_W'(843314856), Z_W'(497837829), Z_W'(263043836), Z_W'(133525158),
      Z_W'(67021686),  Z_W'(33543515),  Z_W'(16775850),  Z_W'(8388437),
      Z_W'(4194282),   Z_W'(2097149),   Z_W'(1048575),   Z_W'(524287),
      Z_W'(262143),    Z_W'(131071),    Z_W'(65535),     Z_W'(32767),
      Z_W'(16383),     Z_W'(8191),      Z_W'(4095),      Z_W'(2047),
      Z_W'(1023),      Z_W'(511),       Z_W'(255),       Z_W'(127)
   };

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEAD_ZONE,
      CSR_TILT_LIMIT,
      CSR_TURN_GAIN,
      CSR_LINEAR_GAIN
   } csr_index_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] accel_x;
      logic signed [ACC_W-1:0] accel_y;
      logic signed [ACC_W-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] forward_speed;
      logic signed [OUT_W-1:0] turn_rate;
      logic                    within_limits;
   } rsp_type;

   typedef struct packed {
      logic [DZ_W-1:0]   dead_zone;
      logic [LIM_W-1:0]  tilt_limit;
      logic [GAIN_W-1:0] turn_gain;
      logic [GAIN_W-1:0] linear_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dead_zone:   DZ_W'(410),
      tilt_limit:  LIM_W'(5147),
      turn_gain:   GAIN_W'(8192),
      linear_gain: GAIN_W'(2048)
   };

endpackage

/* src/tilt_to_velocity_deadband_core.sv */
// Top level of the tilt-to-velocity dead band core: registers and pipeline.
//
// Turns one three-axis accelerometer sample into a forward speed and a turn
// rate. Two tilt angles, atan2(y,x) and atan2(z,x), come from a two-lane
// pipelined CORDIC; both are checked against tilt_limit, pass a dead band
// and are scaled by their gains with 16 bit saturation.
//
// Input: a sample beat on req_data is taken at a clock edge with start high
// and busy low. busy is high only in the cycle that follows reset, so a new
// sample may be taken in every cycle after that.
// Output: each result beat shows on rsp_data for one cycle with rsp_valid
// high, once its sample has passed one prep stage, one stage per CORDIC
// rotation, then rounding, band, multiply and output stages. The receiver
// cannot hold results off and needs none.
// Configuration: csr_we, csr_index and csr_wdata write dead_zone,
// tilt_limit, turn_gain and linear_gain; write them only while no beat is in
// flight. Reset loads their default values and empties the pipeline.
module tilt_to_velocity_deadband_core
   import tvd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type                 cfg_in;
   cfg_type                 cfg_ff;
   logic                    busy_ff;
   logic                    accept;
   logic                    ang_valid;
   logic signed [ANG_W-1:0] turn;
   logic signed [ANG_W-1:0] pitch;

   // Update the addressed register; indexes past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEAD_ZONE:   cfg_in.dead_zone   = csr_wdata[DZ_W-1:0];
            CSR_TILT_LIMIT:  cfg_in.tilt_limit  = csr_wdata[LIM_W-1:0];
            CSR_TURN_GAIN:   cfg_in.turn_gain   = csr_wdata[GAIN_W-1:0];
            CSR_LINEAR_GAIN: cfg_in.linear_gain = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Hold configuration and the post-reset busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= CFG_RESET;
         busy_ff <= 1'b1;
      end else begin
         cfg_ff  <= cfg_in;
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   tvd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .acc_x     (req_data.accel_x),
      .acc_y     (req_data.accel_y),
      .acc_z     (req_data.accel_z),
      .out_valid (ang_valid),
      .turn      (turn),
      .pitch     (pitch)
   );

   tvd_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .turn      (turn),
      .pitch     (pitch),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/tvd_cordic.sv */
// Dual-lane pipelined vectoring CORDIC giving atan2(y,x) and atan2(z,x).
module tvd_cordic
   import tvd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [ACC_W-1:0] acc_x,
   input  logic signed [ACC_W-1:0] acc_y,
   input  logic signed [ACC_W-1:0] acc_z,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] turn,
   output logic signed [ANG_W-1:0] pitch
);

   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] y;
      logic signed [Z_W-1:0] z;
      logic                  zero;
   } lane_type;

   // Scale the sample and fold the left half-plane over by pi
   function automatic lane_type prep(input logic signed [ACC_W-1:0] ax,
                                     input logic signed [ACC_W-1:0] ay);
      lane_type              r;
      logic signed [X_W-1:0] xs;
      logic signed [X_W-1:0] ys;
      xs = {{(X_W-ACC_W-SCALE_SHIFT){ax[ACC_W-1]}}, ax, {SCALE_SHIFT{1'b0}}};
      ys = {{(X_W-ACC_W-SCALE_SHIFT){ay[ACC_W-1]}}, ay, {SCALE_SHIFT{1'b0}}};
      r.zero = (ax == '0) && (ay == '0);
      if (ax[ACC_W-1]) begin
         r.x = -xs;
         r.y = -ys;
         r.z = ay[ACC_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
         r.x = xs;
         r.y = ys;
         r.z = '0;
      end
      return r;
   endfunction

   // One micro-rotation towards the x axis
   function automatic lane_type iter(input lane_type l, input int k);
      lane_type r;
      r = l;
      if (l.y > 0) begin
         r.x = l.x + (l.y >>> k);
         r.y = l.y - (l.x >>> k);
         r.z = l.z + ATAN_Q30[k];
      end else begin
         r.x = l.x - (l.y >>> k);
         r.y = l.y + (l.x >>> k);
         r.z = l.z - ATAN_Q30[k];
      end
      return r;
   endfunction

   // Round Q30 to the output format; the zero vector gives exactly zero
   function automatic logic signed [ANG_W-1:0] round_angle(input lane_type l);
      logic signed [Z_W-1:0] zr;
      zr = l.z + ROUND_HALF;
      return l.zero ? '0 : zr[Z_W-1:ROUND_SHIFT];
   endfunction

   // Lane 0 is turn (y over x), lane 1 is pitch (z over x)
   lane_type                lane_in [0:CORDIC_STEPS][2];
   lane_type                lane_ff [0:CORDIC_STEPS][2];
   logic [CORDIC_STEPS:0]   vld_in;
   logic [CORDIC_STEPS:0]   vld_ff;
   logic                    ang_vld_ff;
   logic signed [ANG_W-1:0] turn_in;
   logic signed [ANG_W-1:0] turn_ff;
   logic signed [ANG_W-1:0] pitch_in;
   logic signed [ANG_W-1:0] pitch_ff;

   assign lane_in[0][0] = prep(acc_x, acc_y);
   assign lane_in[0][1] = prep(acc_x, acc_z);

   // One register stage per rotation
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      for (genvar n = 0; n < 2; n++) begin : g_lane
         assign lane_in[k+1][n] = iter(lane_ff[k][n], k);
      end
   end

   assign vld_in   = {vld_ff[CORDIC_STEPS-1:0], in_valid};
   assign turn_in  = round_angle(lane_ff[CORDIC_STEPS][0]);
   assign pitch_in = round_angle(lane_ff[CORDIC_STEPS][1]);

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         ang_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         ang_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      lane_ff  <= lane_in;
      turn_ff  <= turn_in;
      pitch_ff <= pitch_in;
   end

   assign out_valid = ang_vld_ff;
   assign turn      = turn_ff;
   assign pitch     = pitch_ff;

endmodule

/* src/tvd_post.sv */
// Limit check, dead band, gain scaling and saturation of the two tilt angles.
module tvd_post
   import tvd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] turn,
   input  logic signed [ANG_W-1:0] pitch,
   input  cfg_type                 cfg,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data
);

   localparam logic signed [SH_W:0] SAT_HI = (SH_W+1)'(2**(OUT_W-1) - 1);
   localparam logic signed [SH_W:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [ANG_W-1:0] dead_band(
      input logic signed [ANG_W-1:0] a,
      input logic signed [ANG_W-1:0] dz);
      if (a >= dz) begin
         return a - dz;
      end else if (a <= -dz) begin
         return a + dz;
      end
      return '0;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SH_W:0] v);
      if (v > SAT_HI) begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end else if (v < SAT_LO) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end
      return v[OUT_W-1:0];
   endfunction

   logic signed [ANG_W-1:0]  lim;
   logic signed [ANG_W-1:0]  dz;

   // Band stage
   logic                     b_vld_ff;
   logic                     b_inside_in;
   logic                     b_inside_ff;
   logic signed [ANG_W-1:0]  b_turn_in;
   logic signed [ANG_W-1:0]  b_turn_ff;
   logic signed [ANG_W-1:0]  b_pitch_in;
   logic signed [ANG_W-1:0]  b_pitch_ff;

   // Multiply stage
   logic                     m_vld_ff;
   logic                     m_inside_ff;
   logic signed [PROD_W-1:0] m_turn_in;
   logic signed [PROD_W-1:0] m_turn_ff;
   logic signed [PROD_W-1:0] m_fwd_in;
   logic signed [PROD_W-1:0] m_fwd_ff;

   // Output stage
   logic signed [SH_W-1:0]   o_turn_sh;
   logic signed [SH_W-1:0]   o_fwd_sh;
   logic signed [SH_W:0]     o_turn_neg;
   logic signed [SH_W:0]     o_fwd_ext;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_in;
   rsp_type                  rsp_ff;

   assign lim = ANG_W'(cfg.tilt_limit);
   assign dz  = ANG_W'(cfg.dead_zone);

   // Check both angles against the limit and apply the dead band
   assign b_inside_in = (turn < lim) && (turn > -lim) && (pitch < lim) && (pitch > -lim);
   assign b_turn_in   = dead_band(turn, dz);
   assign b_pitch_in  = dead_band(pitch, dz);

   // Scale by the gains
   assign m_turn_in = b_turn_ff * $signed({1'b0, cfg.turn_gain});
   assign m_fwd_in  = b_pitch_ff * $signed({1'b0, cfg.linear_gain});

   // Drop the fraction, negate turn, saturate and zero out-of-limit beats
   assign o_turn_sh  = m_turn_ff[PROD_W-1:FRAC_BITS];
   assign o_fwd_sh   = m_fwd_ff[PROD_W-1:FRAC_BITS];
   assign o_turn_neg = -{o_turn_sh[SH_W-1], o_turn_sh};
   assign o_fwd_ext  = {o_fwd_sh[SH_W-1], o_fwd_sh};

   always_comb begin
      rsp_in.within_limits = m_inside_ff;
      rsp_in.forward_speed = m_inside_ff ? sat_out(o_fwd_ext) : '0;
      rsp_in.turn_rate     = m_inside_ff ? sat_out(o_turn_neg) : '0;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_vld_ff     <= in_valid;
         m_vld_ff     <= b_vld_ff;
         rsp_valid_ff <= m_vld_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      b_inside_ff <= b_inside_in;
      b_turn_ff   <= b_turn_in;
      b_pitch_ff  <= b_pitch_in;
      m_inside_ff <= b_inside_ff;
      m_turn_ff   <= m_turn_in;
      m_fwd_ff    <= m_fwd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/tvd_checker.sv */
// Port-level checks of the tilt-to-velocity dead band core, bound to the top level.
module tvd_checker
   import tvd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Every accepted beat comes out after the fixed latency
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted beat produced no result");

   // No result without a beat taken the fixed latency earlier
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching input beat");

   // Out-of-limit results carry zero commands
   a_out_of_limit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.within_limits) |->
         (rsp_data.forward_speed == '0) && (rsp_data.turn_rate == '0))
      else $error("non-zero command outside the tilt limit");

endmodule

bind tilt_to_velocity_deadband_core tvd_checker u_tvd_checker (.*);

/* dv/tb_tilt_to_velocity_deadband_core.sv */
// Self-checking testbench for the tilt-to-velocity dead band core.
`timescale 1ns / 1ps

module tb_tilt_to_velocity_deadband_core;
   import tvd_pkg::*;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTING_COUNT   = 7;
   localparam int REPORT_LIMIT    = 10;

   // Tracks the register file and predicts one velocity beat per sample
   class velocity_scoreboard;
      rsp_type           expected_q[$];
      logic [DZ_W-1:0]   dead_zone;
      logic [LIM_W-1:0]  tilt_limit;
      logic [GAIN_W-1:0] turn_gain;
      logic [GAIN_W-1:0] linear_gain;
      int                checked;
      int                mismatches;

      function new();
         dead_zone   = 410;
         tilt_limit  = 5147;
         turn_gain   = 8192;
         linear_gain = 2048;
         checked     = 0;
         mismatches  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_DEAD_ZONE:   dead_zone   = value[DZ_W-1:0];
            CSR_TILT_LIMIT:  tilt_limit  = value[LIM_W-1:0];
            CSR_TURN_GAIN:   turn_gain   = value[GAIN_W-1:0];
            CSR_LINEAR_GAIN: linear_gain = value[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Vectoring CORDIC, angle in Q30 during the walk, rounded to Q12
      function longint tilt_angle(longint num, longint den);
         longint step_atan [CORDIC_STEPS];
         longint x, y, z, xs, ys;
         step_atan = '{843314856, 497837829, 263043836, 133525158,
                       67021686, 33543515, 16775850, 8388437,
                       4194282, 2097149, 1048575, 524287,
                       262143, 131071};
         if (num == 0 && den == 0)
            return 0;
         x = den * 65536;
         y = num * 65536;
         z = 0;
         // fold the left half plane over by a half turn
         if (x < 0) begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys;
               y = y - xs;
               z = z + step_atan[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - step_atan[i];
            end
         end
         return (z + (64'sd1 <<< 17)) >>> 18;
      endfunction

      function longint dead_band(longint a);
         longint dz;
         dz = dead_zone;
         if (a >= dz)
            return a - dz;
         if (a <= -dz)
            return a + dz;
         return 0;
      endfunction

      function longint clamp16(longint v);
         if (v > 32767)
            return 32767;
         if (v < -32768)
            return -32768;
         return v;
      endfunction

      function void note_sample(req_type s);
         longint  turn, pitch, lim, fwd, rate, tg, lg;
         rsp_type r;
         turn  = tilt_angle(longint'($signed(s.accel_y)), longint'($signed(s.accel_x)));
         pitch = tilt_angle(longint'($signed(s.accel_z)), longint'($signed(s.accel_x)));
         lim   = tilt_limit;
         tg    = turn_gain;
         lg    = linear_gain;
         fwd   = 0;
         rate  = 0;
         r.within_limits = (turn < lim && turn > -lim && pitch < lim && pitch > -lim);
         if (r.within_limits) begin
            fwd  = clamp16((dead_band(pitch) * lg) >>> FRAC_BITS);
            rate = clamp16(-((dead_band(turn) * tg) >>> FRAC_BITS));
         end
         r.forward_speed = OUT_W'(fwd);
         r.turn_rate     = OUT_W'(rate);
         expected_q.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result beat with no sample pending: fwd %0d rate %0d in %0b",
                        got.forward_speed, got.turn_rate, got.within_limits);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.forward_speed !== want.forward_speed || got.turn_rate !== want.turn_rate ||
             got.within_limits !== want.within_limits) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"mismatch on beat %0d: expected fwd %0d rate %0d in %0b,",
                         " got fwd %0d rate %0d in %0b"},
                        checked, want.forward_speed, want.turn_rate, want.within_limits,
                        got.forward_speed, got.turn_rate, got.within_limits);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   velocity_scoreboard sb = new();
   int                 sent = 0;
   int                 quiet_cycles = 0;

   tilt_to_velocity_deadband_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Sample outputs mid-cycle, away from the driving edge
   always @(negedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_data);
   end

   // Abort when nothing moves for too long
   always @(negedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
               $display("watchdog expired after %0d quiet cycles", quiet_cycles);
               $display("tilt_to_velocity_deadband_core verification failed");
               $finish;
            end
         end
      end
   end

   function automatic int rand_in(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic logic signed [ACC_W-1:0] corner_value();
      case ($urandom_range(0, 5))
         0: return ACC_W'(0);
         1: return ACC_W'(1);
         2: return ACC_W'(-1);
         3: return ACC_W'(32767);
         4: return ACC_W'(-32768);
         default: return ACC_W'(rand_in(64));
      endcase
   endfunction

   // Half moderate tilts with x forward, plus full-range and corner noise
   function automatic req_type random_sample();
      req_type s;
      int      x;
      case ($urandom_range(0, 3))
         0, 1: begin
            x = $urandom_range(2000, 32767);
            s.accel_x = ACC_W'(x);
            s.accel_y = ACC_W'(rand_in(x >> $urandom_range(0, 6)));
            s.accel_z = ACC_W'(rand_in(x >> $urandom_range(0, 6)));
         end
         2: s = req_type'({$urandom, 16'($urandom)});
         default: begin
            s.accel_x = corner_value();
            s.accel_y = corner_value();
            s.accel_z = corner_value();
         end
      endcase
      return s;
   endfunction

   // Hold start low for a random number of cycles, by the current idle rate
   task automatic idle_gap();
      int pct;
      pct = (sent < 150) ? 8 : (sent < 300) ? 81 : 0;
      while ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_sample(input req_type s);
      idle_gap();
      start    <= 1'b1;
      req_data <= s;
      @(negedge clock);
      while (busy) begin
         @(posedge clock);
         @(negedge clock);
      end
      sb.note_sample(s);
      sent++;
      @(posedge clock);
   endtask

   task automatic send_xyz(input int x, input int y, input int z);
      req_type s;
      s.accel_x = ACC_W'(x);
      s.accel_y = ACC_W'(y);
      s.accel_z = ACC_W'(z);
      send_sample(s);
   endtask

   // Stop sending and wait until every predicted beat has come out
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_W-1:0] dz, input logic [CSR_W-1:0] lim,
                                input logic [CSR_W-1:0] tg, input logic [CSR_W-1:0] lg);
      logic [CSR_W-1:0] vals [4];
      vals = '{dz, lim, tg, lg};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(csr_index_type'(i), vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int phase_beats [SETTING_COUNT];
      bit failed;
      phase_beats = '{60, 70, 60, 40, 70, 70, 70};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < SETTING_COUNT; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               // no dead band, widest limit, full gains: drives saturation
               1: write_setting(16'd0, 16'd12868, 16'd65535, 16'd65535);
               // widest dead band, zero and minimal gains
               2: write_setting(16'd12868, 16'd12868, 16'd0, 16'd1);
               // zero limit: every sample is out of range
               3: write_setting(16'd410, 16'd0, 16'd8192, 16'd2048);
               // upper bits set beyond the register widths must be dropped
               4: write_setting(16'hC0CD, 16'h4BB8, 16'd4096, 16'd40960);
               default: write_setting(CSR_W'($urandom_range(0, 12868)),
                                      CSR_W'($urandom_range(1, 12868)),
                                      CSR_W'($urandom_range(0, 65535)),
                                      CSR_W'($urandom_range(0, 65535)));
            endcase
         end

         // Directed corners under the reset register values
         if (p == 0) begin
            send_xyz(0, 0, 0);               // zero vector
            send_xyz(0, 0, 1);               // pitch a quarter turn
            send_xyz(1, 0, 0);
            send_xyz(-1, 0, 0);              // half turn, positive side
            send_xyz(-1, -1, -1);            // half turn folded to negative side
            send_xyz(32767, 32767, 32767);
            send_xyz(32767, -32768, -32768);
            send_xyz(-32768, -32768, -32768);
            send_xyz(-32768, 32767, 32767);
            send_xyz(32767, 0, 0);
            send_xyz(32767, 1638, -1638);    // inside the dead band
            send_xyz(32767, 3300, -3300);    // near the dead band edge
            send_xyz(32767, 11000, -11000);
            send_xyz(10000, 30000, 0);       // just inside the tilt limit
            send_xyz(10000, 31000, 0);       // just beyond the tilt limit
            send_xyz(0, -32768, 0);
            send_xyz(0, 32767, -32768);
            send_xyz(-32768, 0, 0);
            send_xyz(-32768, -1, 0);
            send_xyz(5, -5, 5);
         end

         for (int n = 0; n < phase_beats[p]; n++)
            send_sample(random_sample());
      end

      drain();
      failed = (sb.mismatches != 0) || (sb.pending() != 0);
      $display("sent %0d samples over %0d register settings, checked %0d velocity beats",
               sent, SETTING_COUNT, sb.checked);
      $display("mismatching beats: %0d, beats still awaited: %0d", sb.mismatches, sb.pending());
      if (!failed)
         $display("tilt_to_velocity_deadband_core verification clean");
      else
         $display("tilt_to_velocity_deadband_core verification failed");
      $finish;
   end

endmodule
